// File: sv/bsle_pkg.sv
// bsle_pkg: shared types and constants for the button shift layer event block
// no dependencies
`timescale 1ns / 1ps

package bsle_pkg;

  // width of the button mask carried by one sample
  localparam int BTN_W = 12;
  // width of the key index field of one result beat
  localparam int KEY_W = 4;
  // default number of mapped keys
  localparam int NUM_KEYS_DEF = 12;

  // one event slot: a lane can raise up to two of these per sample
  typedef struct packed {
    logic vld;
    logic layer;
    logic pressed;
  } slot_t;

  // low slot first, high slot second, in report order
  typedef struct packed {
    slot_t hi;
    slot_t lo;
  } lane_ev_t;

endpackage

// File: sv/bsle_if.sv
// bsle_in_if and bsle_out_if: valid/ready channels for samples and key events
// depends on bsle_pkg for field widths
`timescale 1ns / 1ps

interface bsle_in_if;
  logic                       valid;
  logic                       ready;
  logic [bsle_pkg::BTN_W-1:0] button_bits;
  logic                       shift_held;

  modport source(output valid, output button_bits, output shift_held, input ready);
  modport sink(input valid, input button_bits, input shift_held, output ready);
endinterface

interface bsle_out_if;
  logic                       valid;
  logic                       ready;
  logic [bsle_pkg::KEY_W-1:0] key_index;
  logic                       shift_layer;
  logic                       pressed;
  logic                       last_event;

  modport source(output valid, output key_index, output shift_layer, output pressed,
                 output last_event, input ready);
  modport sink(input valid, input key_index, input shift_layer, input pressed,
               input last_event, output ready);
endinterface

// File: sv/bsle_lane.sv
// bsle_lane: per-key core, holds the standard and shift layer flags of one key
// and decides the up to two events a sample causes for it; uses bsle_pkg
`timescale 1ns / 1ps

module bsle_lane (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic               shift,
  input  logic               cur,
  input  logic               diff,
  output bsle_pkg::lane_ev_t ev
);

  logic std_down;
  logic std_down_next;
  logic shf_down;
  logic shf_down_next;

  always_comb begin
    ev            = '0;
    std_down_next = std_down;
    shf_down_next = shf_down;
    if (shift) begin
      if (diff) begin
        if (std_down) begin
          // changed while shift held: only drop the standard press
          ev.lo         = '{vld: 1'b1, layer: 1'b0, pressed: 1'b0};
          std_down_next = 1'b0;
        end else begin
          ev.lo         = '{vld: 1'b1, layer: 1'b1, pressed: cur};
          shf_down_next = cur;
        end
      end
    end else begin
      if (shf_down) begin
        ev.lo         = '{vld: 1'b1, layer: 1'b1, pressed: 1'b0};
        shf_down_next = 1'b0;
      end
      if (diff) begin
        ev.hi         = '{vld: 1'b1, layer: 1'b0, pressed: cur};
        std_down_next = cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      std_down <= 1'b0;
      shf_down <= 1'b0;
    end else if (load) begin
      std_down <= std_down_next;
      shf_down <= shf_down_next;
    end
  end

endmodule

// File: sv/bsle_merge.sv
// bsle_merge: collects one sample's lane events, sends them one beat per
// cycle when not stalled, lowest key first, via an output reg; uses bsle_pkg
`timescale 1ns / 1ps

module bsle_merge #(
  parameter int NUM_KEYS = bsle_pkg::NUM_KEYS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  bsle_pkg::lane_ev_t [NUM_KEYS-1:0] lane_ev,
  output logic                              can_load,
  bsle_out_if.source                        key_out
);

  localparam int NSLOT = 2 * NUM_KEYS;

  logic [NSLOT-1:0] pend;
  logic [NSLOT-1:0] pend_next;
  logic [NSLOT-1:0] layer_q;
  logic [NSLOT-1:0] pressed_q;
  logic [NSLOT-1:0] low;
  logic [NSLOT-1:0] rest;
  logic             pop;

  logic                       sel_layer;
  logic                       sel_pressed;
  logic [bsle_pkg::KEY_W-1:0] sel_key;

  assign low  = pend & (~pend + NSLOT'(1));
  assign rest = pend & ~low;
  assign pop  = (|pend) && (!key_out.valid || key_out.ready);
  // next sample may enter once the pending set is empty or drains this cycle
  assign can_load = pop ? (rest == '0) : (pend == '0);

  always_comb begin
    sel_layer   = 1'b0;
    sel_pressed = 1'b0;
    sel_key     = '0;
    for (int s = 0; s < NSLOT; s++) begin
      if (low[s]) begin
        sel_layer   = layer_q[s];
        sel_pressed = pressed_q[s];
        sel_key     = bsle_pkg::KEY_W'(s >> 1);
      end
    end
  end

  always_comb begin
    pend_next = pend;
    if (load) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        pend_next[2*k]   = lane_ev[k].lo.vld;
        pend_next[2*k+1] = lane_ev[k].hi.vld;
      end
    end else if (pop) begin
      pend_next = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend          <= '0;
      key_out.valid <= 1'b0;
    end else begin
      pend <= pend_next;
      if (pop) begin
        key_out.valid <= 1'b1;
      end else if (key_out.ready) begin
        key_out.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        layer_q[2*k]     <= lane_ev[k].lo.layer;
        pressed_q[2*k]   <= lane_ev[k].lo.pressed;
        layer_q[2*k+1]   <= lane_ev[k].hi.layer;
        pressed_q[2*k+1] <= lane_ev[k].hi.pressed;
      end
    end
    if (pop) begin
      key_out.key_index   <= sel_key;
      key_out.shift_layer <= sel_layer;
      key_out.pressed     <= sel_pressed;
      key_out.last_event  <= (rest == '0);
    end
  end

endmodule

// File: sv/button_shift_layer_events.sv
// button_shift_layer_events: top level, one lane per key plus the event merger
// depends on bsle_pkg, bsle_if, bsle_lane, bsle_merge
`timescale 1ns / 1ps

// Usage
// sample channel: one beat is a controller sample, button_bits (bit i is key i)
// and shift_held. key_out channel: one beat per key event, in key order, with
// the low-index event of a key first; last_event marks the final beat that a
// sample caused. A sample that changes nothing and releases nothing causes no
// beat at all.
// The first event of a sample passes through the merger's pending set and then
// its output register. Throughput: events leave one per cycle while the
// receiver is ready; a sample causes up to 2*NUM_KEYS events and the merger's
// pending set drains one beat at a time. The next sample is taken in the same
// cycle as the last event of the previous one moves into the output register.
// Reset clears the previous mask, both layer flags of every key and all
// pending events. When the receiver stalls, the output register holds its beat
// and the block stops taking samples once its pending set is not draining.
module button_shift_layer_events #(
  parameter int NUM_KEYS = bsle_pkg::NUM_KEYS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  bsle_in_if.sink     sample,
  bsle_out_if.source  key_out
);

  logic [bsle_pkg::BTN_W-1:0] previous_buttons;
  logic [bsle_pkg::BTN_W-1:0] changed;
  logic                       accept;
  logic                       can_load;

  bsle_pkg::lane_ev_t [NUM_KEYS-1:0] lane_ev;

  assign sample.ready = can_load;
  assign accept       = sample.valid && can_load;
  assign changed      = sample.button_bits ^ previous_buttons;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_buttons <= '0;
    end else if (accept) begin
      previous_buttons <= sample.button_bits;
    end
  end

  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_lane
    logic cur;
    logic diff;
    if (i < bsle_pkg::BTN_W) begin : g_btn
      assign cur  = sample.button_bits[i];
      assign diff = changed[i];
    end else begin : g_none
      // keys past the mask width stay released
      assign cur  = 1'b0;
      assign diff = 1'b0;
    end

    bsle_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .load  (accept),
      .shift (sample.shift_held),
      .cur   (cur),
      .diff  (diff),
      .ev    (lane_ev[i])
    );
  end

  bsle_merge #(
    .NUM_KEYS(NUM_KEYS)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .lane_ev  (lane_ev),
    .can_load (can_load),
    .key_out  (key_out)
  );

endmodule
